>>> rtl/core/erv_pkg.sv
// package for the euler vector rotation core: constants, types, sine table parameters
`timescale 1ns / 1ps
package erv_pkg;

  localparam int unsigned SineTableDepthDef = 256;
  // vector format in fraction bits; the matrix is unitless, so it never enters the math
  localparam int unsigned VectorFracBitsDef = 16;
  localparam int unsigned AngleW = 16;
  localparam int unsigned VecW = 32;
  localparam int unsigned TrigW = 18;   // signed, +/-65536
  localparam int unsigned ElemW = 18;   // matrix element, signed Q1.16
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegAngleX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngleY = 2'd1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegAngleZ = 2'd2;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [VecW-1:0] z;
  } vec_t;

endpackage

>>> rtl/core/erv_if.sv
// valid/ready stream and configuration write interfaces
`timescale 1ns / 1ps
interface erv_vec_if;
  import erv_pkg::*;
  logic valid;
  logic ready;
  logic signed [VecW-1:0] x;
  logic signed [VecW-1:0] y;
  logic signed [VecW-1:0] z;
  modport source (output valid, x, y, z, input ready);
  modport sink (input valid, x, y, z, output ready);
endinterface

interface erv_cfg_if;
  import erv_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/erv_trig.sv
// quarter-wave sine/cosine lookup for one binary angle
`timescale 1ns / 1ps
module erv_trig import erv_pkg::*; #(
  parameter int unsigned SineTableDepth = SineTableDepthDef
) (
  input  logic [AngleW-1:0]        angle_i,
  output logic signed [TrigW-1:0]  sin_o,
  output logic signed [TrigW-1:0]  cos_o
);
  localparam int unsigned IdxW = $clog2(SineTableDepth) + 1;
  localparam int unsigned PosW = AngleW - 2;

  logic [16:0] tab [SineTableDepth+1];
  for (genvar k = 0; k <= SineTableDepth; k++) begin : g_tab
    // angle in Q2.30, its square, then a ten term series, all at elaboration
    localparam longint unsigned X =
      (HalfPiQ30 * longint'(k) + SineTableDepth / 2) / SineTableDepth;
    localparam longint unsigned X2 = (X * X + (64'd1 << 29)) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 64'd6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam longint unsigned T8 = ((T7 * X2) >> 30) / 64'd272;
    localparam longint unsigned T9 = ((T8 * X2) >> 30) / 64'd342;
    localparam longint unsigned Sum = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9;
    localparam longint unsigned Q = (Sum + (64'd1 << 13)) >> 14;
    localparam logic [16:0] Entry = (Q > 64'd65536) ? 17'd65536 : 17'(Q);
    assign tab[k] = Entry;
  end

  function automatic logic signed [TrigW-1:0] lookup(input logic [AngleW-1:0] a,
                                                     input logic [16:0] t [SineTableDepth+1]);
    logic [PosW+IdxW-1:0] prod;
    logic [IdxW-1:0] i;
    logic [16:0] v;
    prod = PosW'(a[PosW-1:0]) * (PosW+IdxW)'(SineTableDepth);
    i = prod[PosW+IdxW-1:PosW];
    v = a[PosW] ? t[IdxW'(SineTableDepth) - i] : t[i];
    return a[PosW+1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic [AngleW-1:0] cos_angle;
  assign cos_angle = angle_i + AngleW'(16384);
  assign sin_o = lookup(angle_i, tab);
  assign cos_o = lookup(cos_angle, tab);
endmodule

>>> rtl/core/euler_rotate_vector_core.sv
// top level of the euler angle vector rotation core
`timescale 1ns / 1ps
// Rotates each vector request by Rz(gamma)*Ry(beta)*Rx(alpha), angles taken from
// three 16-bit binary angle registers (65536 = one turn). The matrix is rebuilt from
// the registers through a four stage front end (table lookup, pair products, triple
// products and rounding), so it is current once a register write has passed all four;
// the block holds the input ready low until then after a write, after reset,
// and in any cycle where a write is offered. Vectors then run through a three stage
// datapath: nine element*component products, row sums, rounding/saturation into the
// output register. One vector per cycle is accepted while the input ready is high;
// an accepted vector passes the product, sum and output registers in turn before it
// is presented. A stall on the output freezes the whole pipe without loss.
// Configuration must only be written while the block is idle.
module euler_rotate_vector_core import erv_pkg::*; #(
  parameter int unsigned SineTableDepth = SineTableDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  erv_cfg_if.sink   cfg,
  erv_vec_if.sink   in_vec,
  erv_vec_if.source out_vec
);
  localparam int unsigned Stages = 3;
  localparam int unsigned ProdW = VecW + ElemW;
  localparam int unsigned SumW = ProdW + 2;
  // vector format passes through unchanged: the matrix is unitless
  localparam int unsigned RndSh = 16;
  // cycles for a new angle to reach the matrix registers
  localparam int unsigned SettleCycles = 4;

  // configuration registers
  logic [AngleW-1:0] ang_q [3];
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) ang_q[i] <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegAngleX: ang_q[0] <= cfg.data;
        RegAngleY: ang_q[1] <= cfg.data;
        RegAngleZ: ang_q[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // hold off vectors until the matrix reflects the registers
  logic [2:0] settle_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 3'(SettleCycles);
    end else if (cfg.valid && cfg.ready) begin
      settle_q <= 3'(SettleCycles);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  // matrix front end, stage 1: sine/cosine
  logic signed [TrigW-1:0] s_w [3], c_w [3];
  logic signed [TrigW-1:0] s_q [3], c_q [3];
  for (genvar a = 0; a < 3; a++) begin : g_trig
    erv_trig #(.SineTableDepth(SineTableDepth)) u_trig (
      .angle_i(ang_q[a]), .sin_o(s_w[a]), .cos_o(c_w[a]));
  end
  always_ff @(posedge clk_i) begin
    s_q <= s_w;
    c_q <= c_w;
  end

  // stage 2: pair products in Q32 (|v| <= 2^32)
  logic signed [35:0] sxsy_q, cxsy_q, cycz_q, cxsz_q, sxsz_q, cysz_q;
  logic signed [35:0] cxcz_q, sxcz_q, sxcy_q, cxcy_q;
  logic signed [TrigW-1:0] sy2_q, sz2_q, cz2_q;
  always_ff @(posedge clk_i) begin
    sxsy_q <= s_q[0] * s_q[1];
    cxsy_q <= c_q[0] * s_q[1];
    cycz_q <= c_q[1] * c_q[2];
    cxsz_q <= c_q[0] * s_q[2];
    sxsz_q <= s_q[0] * s_q[2];
    cysz_q <= c_q[1] * s_q[2];
    cxcz_q <= c_q[0] * c_q[2];
    sxcz_q <= s_q[0] * c_q[2];
    sxcy_q <= s_q[0] * c_q[1];
    cxcy_q <= c_q[0] * c_q[1];
    sy2_q <= s_q[1];
    sz2_q <= s_q[2];
    cz2_q <= c_q[2];
  end

  // stage 3: elements at Q48
  logic signed [55:0] e_q [9];
  always_ff @(posedge clk_i) begin
    e_q[0] <= 56'(cycz_q) <<< 16;
    e_q[1] <= sxsy_q * cz2_q - (56'(cxsz_q) <<< 16);
    e_q[2] <= cxsy_q * cz2_q + (56'(sxsz_q) <<< 16);
    e_q[3] <= 56'(cysz_q) <<< 16;
    e_q[4] <= sxsy_q * sz2_q + (56'(cxcz_q) <<< 16);
    e_q[5] <= cxsy_q * sz2_q - (56'(sxcz_q) <<< 16);
    e_q[6] <= -(56'(sy2_q) <<< 32);
    e_q[7] <= 56'(sxcy_q) <<< 16;
    e_q[8] <= 56'(cxcy_q) <<< 16;
  end

  // stage 4: round to Q16
  logic signed [ElemW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      m_q[i] <= ElemW'((e_q[i] + 56'sd2147483648) >>> 32);
    end
  end

  // vector datapath
  logic [Stages-1:0] vld_q;
  logic adv;
  logic in_rdy;
  assign adv = !vld_q[Stages-1] || out_vec.ready;
  assign in_rdy = adv && (settle_q == '0) && !cfg.valid;
  assign in_vec.ready = in_rdy;

  logic signed [ProdW-1:0] p_q [9];
  logic signed [SumW-1:0]  r_q [3];
  logic signed [VecW-1:0]  o_q [3];
  logic signed [VecW-1:0]  v [3];
  assign v[0] = in_vec.x;
  assign v[1] = in_vec.y;
  assign v[2] = in_vec.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_vec.valid && in_rdy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) p_q[3*r+c] <= m_q[3*r+c] * v[c];
        r_q[r] <= SumW'(p_q[3*r]) + SumW'(p_q[3*r+1]) + SumW'(p_q[3*r+2])
                  + SumW'(1 << (RndSh - 1));
      end
      for (int r = 0; r < 3; r++) begin
        if ((r_q[r] >>> RndSh) > SumW'(64'sh7FFFFFFF)) o_q[r] <= 32'h7FFFFFFF;
        else if ((r_q[r] >>> RndSh) < -SumW'(64'sh80000000)) o_q[r] <= 32'h80000000;
        else o_q[r] <= VecW'(r_q[r] >>> RndSh);
      end
    end
  end

  assign out_vec.valid = vld_q[Stages-1];
  assign out_vec.x = o_q[0];
  assign out_vec.y = o_q[1];
  assign out_vec.z = o_q[2];
endmodule

>>> rtl/core/erv_checker.sv
// port-level assertions for the rotation core, bound to the top level
`timescale 1ns / 1ps
module erv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_x
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_x)) else $error("output dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while output stalled");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing");
endmodule

bind euler_rotate_vector_core erv_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_vec.valid), .in_ready(in_vec.ready),
  .out_valid(out_vec.valid), .out_ready(out_vec.ready), .out_x(out_vec.x));
